>>> rtl/fractal_value_noise_2d_assert.svh
// Assertion helpers for the noise block.
`ifndef FRACTAL_VALUE_NOISE_2D_ASSERT_SVH
`define FRACTAL_VALUE_NOISE_2D_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define FVN_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("fvn assertion failed");

// next-cycle implication, disabled while reset is low
`define FVN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("fvn assertion failed");

`endif

>>> rtl/fvn_pkg.sv
`default_nettype none

package fvn_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int FRACTION_BITS = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int WIN_W         = IDX_W + FRACTION_BITS;

  // binary point of the scaled coordinate: Q16.16 * Q0.24 and Q16.16 * Q16.16
  localparam int FB_HEIGHT = 40;
  localparam int FB_DETAIL = 32;
  localparam int SH_MAX    = FB_HEIGHT - FB_DETAIL;
  localparam int SH_W      = $clog2(SH_MAX + 1);
  localparam int PW_LO     = FB_DETAIL - FRACTION_BITS;
  localparam int PW_W      = WIN_W + SH_MAX;

  localparam int MAX_OCT = 8;
  localparam int OCT_W   = $clog2(MAX_OCT);
  localparam int CNT_W   = 4;

  localparam int VAL_W  = 16;
  localparam int W_W    = FRACTION_BITS + 1;
  localparam int SS_W   = FRACTION_BITS + 2;
  localparam int AMP_W  = 17;
  localparam int GAIN_W = 16;
  localparam int BF_W   = 24;
  localparam int SUM_W  = 22;
  localparam int OUT_W  = 20;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 48;
  localparam int CFG_W  = 24;

  localparam logic [IDX_W-1:0]  HASH_MUL   = IDX_W'(57);
  localparam logic [AMP_W-1:0]  AMP_ONE    = AMP_W'(1) << 16;
  localparam logic [SS_W-1:0]   SS_THREE   = SS_W'(3) << FRACTION_BITS;
  localparam logic [BF_W-1:0]   BF_RESET   = BF_W'(83886);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(39322);
  localparam logic [CNT_W-1:0]  CNT_RESET  = CNT_W'(6);

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_HEIGHT = 2'd1;
  localparam logic [1:0] CMD_DETAIL = 2'd2;

  localparam logic [1:0] CFG_BASE_FREQ = 2'd0;
  localparam logic [1:0] CFG_OCT_GAIN  = 2'd1;
  localparam logic [1:0] CFG_OCT_COUNT = 2'd2;

  typedef logic signed [MUL_W-1:0] mop_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SQ,
    ST_WT,
    ST_B0,
    ST_B1,
    ST_B2,
    ST_B3,
    ST_B4,
    ST_ACC,
    ST_FINISH
  } state_e;

  typedef struct packed {
    state_e step;
    logic   take;
    logic   tbl_we;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic detail;
    logic cnt_zero;
    logic last_oct;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/fvn_ram.sv
`default_nettype none

module fvn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/fvn_ctrl.sv
`default_nettype none

module fvn_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        cmd_i,
  output logic                   in_ready_o,
  input  wire fvn_pkg::dp_stat_t stat_i,
  output fvn_pkg::dp_cmd_t       ctl_o
);

  fvn_pkg::state_e state_q, state_d;
  logic            acc;

  assign acc = in_valid_i && (state_q == fvn_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      fvn_pkg::ST_IDLE: begin
        if (acc && (cmd_i == fvn_pkg::CMD_HEIGHT || cmd_i == fvn_pkg::CMD_DETAIL)) begin
          state_d = fvn_pkg::ST_SCALE;
        end
      end
      fvn_pkg::ST_SCALE: begin
        if (!stat_i.detail && stat_i.cnt_zero) begin
          state_d = fvn_pkg::ST_FINISH;
        end else begin
          state_d = fvn_pkg::ST_SQ;
        end
      end
      fvn_pkg::ST_SQ: state_d = fvn_pkg::ST_WT;
      fvn_pkg::ST_WT: state_d = fvn_pkg::ST_B0;
      fvn_pkg::ST_B0: state_d = fvn_pkg::ST_B1;
      fvn_pkg::ST_B1: state_d = fvn_pkg::ST_B2;
      fvn_pkg::ST_B2: state_d = fvn_pkg::ST_B3;
      fvn_pkg::ST_B3: state_d = fvn_pkg::ST_B4;
      fvn_pkg::ST_B4: begin
        state_d = stat_i.detail ? fvn_pkg::ST_FINISH : fvn_pkg::ST_ACC;
      end
      fvn_pkg::ST_ACC: begin
        state_d = stat_i.last_oct ? fvn_pkg::ST_FINISH : fvn_pkg::ST_SQ;
      end
      fvn_pkg::ST_FINISH: begin
        if (!stat_i.out_busy) begin
          state_d = fvn_pkg::ST_IDLE;
        end
      end
      default: state_d = fvn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = (state_q == fvn_pkg::ST_IDLE);
    ctl_o.step     = state_q;
    ctl_o.take     = acc;
    ctl_o.tbl_we   = acc && (cmd_i == fvn_pkg::CMD_LOAD);
    ctl_o.out_load = (state_q == fvn_pkg::ST_FINISH) && !stat_i.out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fvn_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/fvn_dp.sv
`default_nettype none

module fvn_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire fvn_pkg::dp_cmd_t                     ctl_i,
  output fvn_pkg::dp_stat_t                         stat_o,
  input  wire logic [1:0]                           cmd_i,
  input  wire logic signed [31:0]                   coord_x_i,
  input  wire logic signed [31:0]                   coord_z_i,
  input  wire logic [31:0]                          detail_scale_i,
  input  wire logic [7:0]                           entry_index_i,
  input  wire logic signed [fvn_pkg::VAL_W-1:0]     entry_value_i,
  input  wire logic                                 cfg_valid_i,
  input  wire logic [1:0]                           cfg_index_i,
  input  wire logic [fvn_pkg::CFG_W-1:0]            cfg_data_i,
  input  wire logic                                 out_ready_i,
  output logic                                      out_valid_o,
  output logic signed [fvn_pkg::OUT_W-1:0]          noise_value_o
);

  // configuration
  logic [fvn_pkg::BF_W-1:0]   bf_q;
  logic [fvn_pkg::GAIN_W-1:0] gain_q;
  logic [fvn_pkg::CNT_W-1:0]  cnt_q, cnt_eff;

  // latched request
  logic signed [31:0] x_q, z_q;
  logic [31:0]        scale_q;
  logic               detail_q;

  // scaled coordinates and octave state
  logic [fvn_pkg::PW_W-1:0]  px_q, pz_q, shx, shz;
  logic [fvn_pkg::SH_W-1:0]  sh;
  logic [fvn_pkg::OCT_W-1:0] oct_q;
  logic [fvn_pkg::WIN_W-1:0] win_x, win_z;
  logic [fvn_pkg::FRACTION_BITS-1:0] fx, fz;
  logic [fvn_pkg::IDX_W-1:0] cx, cz, cx1, row0, row1, raddr;
  logic [fvn_pkg::SS_W-1:0]  tw_x, tw_z;

  // multipliers
  fvn_pkg::mop_t                ma_a, ma_b, mb_a, mb_b;
  logic signed [2*fvn_pkg::MUL_W-1:0] prod_a, prod_b;
  logic [fvn_pkg::PROD_W-1:0]   pa_q, pb_q;

  // blend
  logic [fvn_pkg::VAL_W-1:0]         rdata;
  logic signed [fvn_pkg::VAL_W-1:0]  rdv, v1_q, v3_q, i1_q, i2, o_val;
  logic signed [fvn_pkg::VAL_W:0]    dif, val2;
  logic signed [fvn_pkg::VAL_W+1:0]  bt, s_i1, s_i2, s_o;
  logic [fvn_pkg::W_W-1:0]           wx_q, wz_q, wx_now;
  logic [fvn_pkg::AMP_W-1:0]         amp_q;
  logic signed [fvn_pkg::SUM_W-1:0]  sum_q, sum_d, contrib;
  logic [fvn_pkg::SUM_W-fvn_pkg::OUT_W:0] hi;
  logic signed [fvn_pkg::OUT_W-1:0]  sat;

  // coordinate window: cell index over fraction
  assign sh    = detail_q ? '0 : fvn_pkg::SH_W'(fvn_pkg::SH_MAX) - fvn_pkg::SH_W'(oct_q);
  assign shx   = px_q >> sh;
  assign shz   = pz_q >> sh;
  assign win_x = shx[fvn_pkg::WIN_W-1:0];
  assign win_z = shz[fvn_pkg::WIN_W-1:0];
  assign fx    = win_x[fvn_pkg::FRACTION_BITS-1:0];
  assign fz    = win_z[fvn_pkg::FRACTION_BITS-1:0];
  assign cx    = win_x[fvn_pkg::WIN_W-1:fvn_pkg::FRACTION_BITS];
  assign cz    = win_z[fvn_pkg::WIN_W-1:fvn_pkg::FRACTION_BITS];
  assign cx1   = cx + fvn_pkg::IDX_W'(1);
  assign row0  = cz * fvn_pkg::HASH_MUL;
  assign row1  = row0 + fvn_pkg::HASH_MUL;
  assign tw_x  = fvn_pkg::SS_THREE - {1'b0, fx, 1'b0};
  assign tw_z  = fvn_pkg::SS_THREE - {1'b0, fz, 1'b0};

  // one corner per cycle from SQ to B1
  always_comb begin
    case (ctl_i.step)
      fvn_pkg::ST_SQ: raddr = cx + row0;
      fvn_pkg::ST_WT: raddr = cx1 + row0;
      fvn_pkg::ST_B0: raddr = cx + row1;
      fvn_pkg::ST_B1: raddr = cx1 + row1;
      default:        raddr = cx + row0;
    endcase
  end

  fvn_ram #(
    .WIDTH(fvn_pkg::VAL_W),
    .DEPTH(fvn_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ctl_i.tbl_we),
    .waddr_i(entry_index_i[fvn_pkg::IDX_W-1:0]),
    .wdata_i(entry_value_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rdv    = $signed(rdata);
  assign bt     = $signed(pa_q[fvn_pkg::FRACTION_BITS +: fvn_pkg::VAL_W+2]);
  assign wx_now = pa_q[fvn_pkg::FRACTION_BITS +: fvn_pkg::W_W];
  assign s_i1   = bt + (fvn_pkg::VAL_W+2)'(v1_q);
  assign s_i2   = bt + (fvn_pkg::VAL_W+2)'(v3_q);
  assign s_o    = bt + (fvn_pkg::VAL_W+2)'(i1_q);
  assign i2     = s_i2[fvn_pkg::VAL_W-1:0];
  assign o_val  = s_o[fvn_pkg::VAL_W-1:0];
  assign val2   = {o_val, 1'b0};
  assign contrib = $signed(pa_q[fvn_pkg::FRACTION_BITS +: fvn_pkg::SUM_W]);

  // operand selection for the two shared multipliers
  always_comb begin
    ma_a = '0;
    ma_b = '0;
    mb_a = '0;
    mb_b = '0;
    dif  = '0;
    case (ctl_i.step)
      fvn_pkg::ST_SCALE: begin
        ma_a = fvn_pkg::mop_t'(x_q);
        mb_a = fvn_pkg::mop_t'(z_q);
        ma_b = detail_q ? fvn_pkg::mop_t'(scale_q) : fvn_pkg::mop_t'(bf_q);
        mb_b = ma_b;
      end
      fvn_pkg::ST_SQ: begin
        ma_a = fvn_pkg::mop_t'(fx);
        ma_b = fvn_pkg::mop_t'(fx);
        mb_a = fvn_pkg::mop_t'(fz);
        mb_b = fvn_pkg::mop_t'(fz);
      end
      fvn_pkg::ST_WT: begin
        ma_a = fvn_pkg::mop_t'(pa_q[fvn_pkg::FRACTION_BITS +: fvn_pkg::FRACTION_BITS]);
        ma_b = fvn_pkg::mop_t'(tw_x);
        mb_a = fvn_pkg::mop_t'(pb_q[fvn_pkg::FRACTION_BITS +: fvn_pkg::FRACTION_BITS]);
        mb_b = fvn_pkg::mop_t'(tw_z);
      end
      fvn_pkg::ST_B0: begin
        dif  = (fvn_pkg::VAL_W+1)'(rdv) - (fvn_pkg::VAL_W+1)'(v1_q);
        ma_a = fvn_pkg::mop_t'(wx_now);
        ma_b = fvn_pkg::mop_t'(dif);
      end
      fvn_pkg::ST_B2: begin
        dif  = (fvn_pkg::VAL_W+1)'(rdv) - (fvn_pkg::VAL_W+1)'(v3_q);
        ma_a = fvn_pkg::mop_t'(wx_q);
        ma_b = fvn_pkg::mop_t'(dif);
      end
      fvn_pkg::ST_B3: begin
        dif  = (fvn_pkg::VAL_W+1)'(i2) - (fvn_pkg::VAL_W+1)'(i1_q);
        ma_a = fvn_pkg::mop_t'(wz_q);
        ma_b = fvn_pkg::mop_t'(dif);
      end
      fvn_pkg::ST_B4: begin
        ma_a = fvn_pkg::mop_t'(val2);
        ma_b = fvn_pkg::mop_t'(amp_q);
        mb_a = fvn_pkg::mop_t'(amp_q);
        mb_b = fvn_pkg::mop_t'(gain_q);
      end
      default: begin
        ma_a = '0;
      end
    endcase
  end

  assign prod_a = ma_a * ma_b;
  assign prod_b = mb_a * mb_b;

  always_comb begin
    sum_d = sum_q;
    case (ctl_i.step)
      fvn_pkg::ST_SCALE: sum_d = '0;
      fvn_pkg::ST_B4:    sum_d = detail_q ? fvn_pkg::SUM_W'(val2) : sum_q;
      fvn_pkg::ST_ACC:   sum_d = sum_q + contrib;
      default:           sum_d = sum_q;
    endcase
  end

  // saturate Q.16 sum to the output range
  assign hi = sum_q[fvn_pkg::SUM_W-1:fvn_pkg::OUT_W-1];
  always_comb begin
    if (!sum_q[fvn_pkg::SUM_W-1] && (|hi)) begin
      sat = {1'b0, {(fvn_pkg::OUT_W-1){1'b1}}};
    end else if (sum_q[fvn_pkg::SUM_W-1] && !(&hi)) begin
      sat = {1'b1, {(fvn_pkg::OUT_W-1){1'b0}}};
    end else begin
      sat = sum_q[fvn_pkg::OUT_W-1:0];
    end
  end

  assign cnt_eff = (cnt_q > fvn_pkg::CNT_W'(fvn_pkg::MAX_OCT)) ?
                   fvn_pkg::CNT_W'(fvn_pkg::MAX_OCT) : cnt_q;

  assign stat_o.detail   = detail_q;
  assign stat_o.cnt_zero = (cnt_q == '0);
  assign stat_o.last_oct = (fvn_pkg::CNT_W'(oct_q) == cnt_eff - fvn_pkg::CNT_W'(1));
  assign stat_o.out_busy = out_valid_o && !out_ready_i;

  // control and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bf_q        <= fvn_pkg::BF_RESET;
      gain_q      <= fvn_pkg::GAIN_RESET;
      cnt_q       <= fvn_pkg::CNT_RESET;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          fvn_pkg::CFG_BASE_FREQ: bf_q   <= cfg_data_i[fvn_pkg::BF_W-1:0];
          fvn_pkg::CFG_OCT_GAIN:  gain_q <= cfg_data_i[fvn_pkg::GAIN_W-1:0];
          fvn_pkg::CFG_OCT_COUNT: cnt_q  <= cfg_data_i[fvn_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
      if (ctl_i.out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      x_q      <= coord_x_i;
      z_q      <= coord_z_i;
      scale_q  <= detail_scale_i;
      detail_q <= (cmd_i == fvn_pkg::CMD_DETAIL);
    end
    pa_q  <= prod_a[fvn_pkg::PROD_W-1:0];
    pb_q  <= prod_b[fvn_pkg::PROD_W-1:0];
    sum_q <= sum_d;
    case (ctl_i.step)
      fvn_pkg::ST_SCALE: begin
        px_q  <= prod_a[fvn_pkg::PW_LO +: fvn_pkg::PW_W];
        pz_q  <= prod_b[fvn_pkg::PW_LO +: fvn_pkg::PW_W];
        oct_q <= '0;
        amp_q <= fvn_pkg::AMP_ONE;
      end
      fvn_pkg::ST_WT: v1_q <= rdv;
      fvn_pkg::ST_B0: begin
        wx_q <= wx_now;
        wz_q <= pb_q[fvn_pkg::FRACTION_BITS +: fvn_pkg::W_W];
      end
      fvn_pkg::ST_B1: begin
        v3_q <= rdv;
        i1_q <= s_i1[fvn_pkg::VAL_W-1:0];
      end
      fvn_pkg::ST_ACC: begin
        amp_q <= pb_q[fvn_pkg::FRACTION_BITS +: fvn_pkg::AMP_W];
        oct_q <= oct_q + fvn_pkg::OCT_W'(1);
      end
      default: ;
    endcase
    if (ctl_i.out_load) begin
      noise_value_o <= sat;
    end
  end

endmodule

`default_nettype wire

>>> rtl/fractal_value_noise_2d.sv
// channel  | handshake              | payload
// ---------+------------------------+------------------------------------------------
// input    | in_valid_i/in_ready_o  | cmd_i coord_x_i coord_z_i detail_scale_i
//          |                        | entry_index_i entry_value_i
// output   | out_valid_o/out_ready_i| noise_value_o
// config   | cfg_valid_i/cfg_ready_o| cfg_index_i cfg_data_i
//
// Load request: one table write. Height request: one pass per configured octave;
// detail request: a single pass. Each octave is 8 steps, paced by the table's single
// read port (four corners per octave) and the two shared multipliers.
// Reset clears control and config only; the table is undefined until loaded.
// A finished result waits in the output register; the next request is taken meanwhile,
// and only the finish step stalls while the previous result is still unclaimed.
`default_nettype none

module fractal_value_noise_2d (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // request channel
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [1:0]                        cmd_i,
  input  wire logic signed [31:0]                coord_x_i,
  input  wire logic signed [31:0]                coord_z_i,
  input  wire logic [31:0]                       detail_scale_i,
  input  wire logic [7:0]                        entry_index_i,
  input  wire logic signed [fvn_pkg::VAL_W-1:0]  entry_value_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [fvn_pkg::OUT_W-1:0]       noise_value_o,
  // register writes
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [1:0]                        cfg_index_i,
  input  wire logic [fvn_pkg::CFG_W-1:0]         cfg_data_i
);

  fvn_pkg::dp_cmd_t  ctl_cmd;
  fvn_pkg::dp_stat_t dp_stat;

  // registers are plain flops, always writable
  assign cfg_ready_o = 1'b1;

  // sequencer: one state per datapath step
  fvn_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .cmd_i     (cmd_i),
    .in_ready_o(in_ready_o),
    .stat_i    (dp_stat),
    .ctl_o     (ctl_cmd)
  );

  // datapath: scaling, smoothstep, table, bilinear blend, octave sum
  fvn_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl_cmd),
    .stat_o        (dp_stat),
    .cmd_i         (cmd_i),
    .coord_x_i     (coord_x_i),
    .coord_z_i     (coord_z_i),
    .detail_scale_i(detail_scale_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .noise_value_o (noise_value_o)
  );

`include "fractal_value_noise_2d_assert.svh"

  // a result is only loaded into a free (or draining) output slot
  `FVN_ASSERT_NOW(a_load_free, clk_i, rst_ni, ctl_cmd.out_load, !out_valid_o || out_ready_i)
  // computing requests close the input until they finish
  `FVN_ASSERT_NEXT(a_busy_after_compute, clk_i, rst_ni,
    in_valid_i && in_ready_o && (cmd_i == fvn_pkg::CMD_HEIGHT || cmd_i == fvn_pkg::CMD_DETAIL),
    !in_ready_o)
  // output valid only rises after a finish step
  `FVN_ASSERT_NOW(a_rose_from_load, clk_i, rst_ni, $rose(out_valid_o), $past(ctl_cmd.out_load))
  // table writes happen only on accepted requests
  `FVN_ASSERT_NOW(a_write_on_accept, clk_i, rst_ni, ctl_cmd.tbl_we, in_valid_i && in_ready_o)

endmodule

`default_nettype wire
